@@ rtl/kmaa_pkg.sv @@
`timescale 1ns / 1ps
package kmaa_pkg;

  localparam int unsigned NumClustersDef = 4;
  localparam int unsigned DimsDef        = 4;

  localparam logic [1:0] CMD_CENTROID = 2'd0;
  localparam logic [1:0] CMD_POINT    = 2'd1;
  localparam logic [1:0] CMD_FINALIZE = 2'd2;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_MEAN   = 1'b1;

  // Controls shared by every cluster cell.
  typedef struct packed {
    logic wr_cent;
    logic diff_en;
    logic sq_en;
    logic acc_en;
    logic upd_en;
    logic clr_dist;
    logic clr_all;
  } cell_ctrl_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SQ     = 9'b000000010,
    S_ACC    = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_UPD    = 9'b000010000,
    S_EMIT   = 9'b000100000,
    S_FSTART = 9'b001000000,
    S_FWAIT  = 9'b010000000,
    S_FEMIT  = 9'b100000000
  } state_e;

  // Unsigned add that sticks at all ones.
  function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [65:0] b);
    logic [66:0] s;
    s = {3'b000, a} + {1'b0, b};
    return (s[66:64] != 3'b000) ? {64{1'b1}} : s[63:0];
  endfunction

  // Signed 64-bit accumulate of a signed 32-bit term, clamped at the rails.
  function automatic logic [63:0] sat_add_s64(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {a[63], a} + {{33{b[31]}}, b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

@@ rtl/kmaa_cell.sv @@
`timescale 1ns / 1ps
module kmaa_cell #(
  parameter int unsigned NUM_CENTROIDS = kmaa_pkg::NumClustersDef,
  parameter int unsigned DIMS          = kmaa_pkg::DimsDef,
  parameter int unsigned IDX           = 0,
  localparam int unsigned CW = $clog2(NUM_CENTROIDS),
  localparam int unsigned DW = (DIMS > 1) ? $clog2(DIMS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kmaa_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CW-1:0]            sel_i,
  input  logic [DW-1:0]            dim_i,
  input  logic [31:0]              val_i,
  input  logic [DIMS-1:0][31:0]    point_i,
  input  logic [63:0]              best_d_i,
  input  logic [CW-1:0]            best_idx_i,
  output logic [63:0]              best_d_o,
  output logic [CW-1:0]            best_idx_o,
  output logic [DIMS-1:0][63:0]    sums_o,
  output logic [31:0]              count_o
);
  import kmaa_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [DIMS-1:0][31:0] cent_q;
  logic [DIMS-1:0][63:0] sums_q;
  logic [31:0]           cnt_q;
  logic [63:0]           dist_q;
  logic [32:0]           diff_q;
  logic [65:0]           sq_q;
  logic [63:0]           best_d_q;
  logic [CW-1:0]         best_idx_q;
  logic [32:0]           diff;
  logic                  sel;

  assign sel  = (sel_i == MyIdx);
  assign diff = {val_i[31], val_i} - {cent_q[dim_i][31], cent_q[dim_i]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_q <= '0;
      sums_q <= '0;
      cnt_q  <= '0;
      dist_q <= '0;
    end else begin
      if (ctrl_i.wr_cent && sel) begin
        cent_q[dim_i] <= val_i;
      end
      if (ctrl_i.acc_en) begin
        dist_q <= sat_add_u64(dist_q, sq_q);
      end
      if (ctrl_i.upd_en && sel) begin
        for (int d = 0; d < DIMS; d++) begin
          sums_q[d] <= sat_add_s64(sums_q[d], point_i[d]);
        end
        if (cnt_q != {32{1'b1}}) begin
          cnt_q <= cnt_q + 32'd1;
        end
      end
      if (ctrl_i.clr_dist) begin
        dist_q <= '0;
      end
      if (ctrl_i.clr_all) begin
        sums_q <= '0;
        cnt_q  <= '0;
        dist_q <= '0;
      end
    end
  end

  // Distance datapath and the running minimum handed along the row.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      diff_q <= diff[32] ? (33'd0 - diff) : diff;
    end
    if (ctrl_i.sq_en) begin
      sq_q <= {33'd0, diff_q} * {33'd0, diff_q};
    end
    // Strict compare keeps the lower index on a tie.
    if (dist_q < best_d_i) begin
      best_d_q   <= dist_q;
      best_idx_q <= MyIdx;
    end else begin
      best_d_q   <= best_d_i;
      best_idx_q <= best_idx_i;
    end
  end

  assign best_d_o   = best_d_q;
  assign best_idx_o = best_idx_q;
  assign sums_o     = sums_q;
  assign count_o    = cnt_q;

endmodule

@@ rtl/kmaa_div.sv @@
`timescale 1ns / 1ps
module kmaa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle; quotient shifts into dvd_q.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        dvd_q <= {dvd_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        dvd_q <= {dvd_q[62:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/kmeans_assign_accumulate.sv @@
`timescale 1ns / 1ps
// One k-means assignment pass in signed Q16.16. Each cluster has its own cell holding its
// centroid, running distance, sums and count; the cells sit in a row and pass the running
// minimum distance along it one cell per cycle. A point coordinate passes through difference,
// square and accumulate steps; after the last coordinate of a point the minimum ripples down
// the row, then the winning cluster is updated and the result presented. A centroid write is
// taken in the idle state. Finalize walks every cluster and dimension through a bit-serial
// divider; empty clusters skip the divider.
module kmeans_assign_accumulate #(
  parameter int unsigned NUM_CENTROIDS = kmaa_pkg::NumClustersDef,
  parameter int unsigned DIMS          = kmaa_pkg::DimsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], cluster_sel[3:2], dim_sel[5:4], coord_value[37:6], zero[39:38]
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cluster_id[1:0], dim_id[3:2], mean_value[35:4], best_distance[99:36],
  // point_count[131:100], empty_cluster[132], zero[135:133]
  output logic [135:0] m_axis_tdata,
  // kind[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import kmaa_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CENTROIDS);
  localparam int unsigned DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [CW-1:0] LastCluster = CW'(NUM_CENTROIDS - 1);
  localparam logic [DW-1:0] LastDim     = DW'(DIMS - 1);

  state_e state_q, state_d;

  logic [1:0]  in_cmd, in_csel, in_dsel;
  logic [31:0] in_val;
  logic        accept, csel_ok, dsel_ok;
  logic [7:0]  csel8, dsel8;

  assign in_cmd  = s_axis_tdata[1:0];
  assign in_csel = s_axis_tdata[3:2];
  assign in_dsel = s_axis_tdata[5:4];
  assign in_val  = s_axis_tdata[37:6];
  assign csel8   = {6'd0, in_csel};
  assign dsel8   = {6'd0, in_dsel};
  assign csel_ok = (32'(in_csel) < NUM_CENTROIDS);
  assign dsel_ok = (32'(in_dsel) < DIMS);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;

  cell_ctrl_t          ctrl;
  logic [CW-1:0]       sel;
  logic [DIMS-1:0][31:0] pbuf_q;
  logic                last_q;
  logic [CW-1:0]       scan_q, best_i_q, cidx_q;
  logic [DW-1:0]       didx_q;
  logic [63:0]         best_d_q;
  logic                neg_q;
  logic [31:0]         mean_q;
  logic                div_start, div_done;
  logic [63:0]         div_q, div_dvd;

  logic [63:0]         chain_d [NUM_CENTROIDS+1];
  logic [CW-1:0]       chain_i [NUM_CENTROIDS+1];
  logic [DIMS-1:0][63:0] sums [NUM_CENTROIDS];
  logic [31:0]         counts [NUM_CENTROIDS];

  assign chain_d[0] = {64{1'b1}};
  assign chain_i[0] = '0;

  for (genvar c = 0; c < NUM_CENTROIDS; c++) begin : g_cell
    kmaa_cell #(
      .NUM_CENTROIDS (NUM_CENTROIDS),
      .DIMS          (DIMS),
      .IDX           (c)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_i      (sel),
      .dim_i      (dsel8[DW-1:0]),
      .val_i      (in_val),
      .point_i    (pbuf_q),
      .best_d_i   (chain_d[c]),
      .best_idx_i (chain_i[c]),
      .best_d_o   (chain_d[c+1]),
      .best_idx_o (chain_i[c+1]),
      .sums_o     (sums[c]),
      .count_o    (counts[c])
    );
  end

  logic [63:0] cur_sum;
  logic [31:0] cur_cnt;
  assign cur_sum = sums[cidx_q][didx_q];
  assign cur_cnt = counts[cidx_q];
  assign div_dvd = cur_sum[63] ? (64'd0 - cur_sum) : cur_sum;

  kmaa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cur_cnt),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    ctrl      = '0;
    sel       = csel8[CW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_CENTROID: ctrl.wr_cent = csel_ok && dsel_ok;
            CMD_POINT: begin
              if (dsel_ok) begin
                ctrl.diff_en = 1'b1;
                state_d      = S_SQ;
              end
            end
            CMD_FINALIZE: state_d = S_FSTART;
            default: ;
          endcase
        end
      end
      S_SQ: begin
        ctrl.sq_en = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        ctrl.acc_en = 1'b1;
        state_d     = last_q ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (scan_q == LastCluster) state_d = S_UPD;
      end
      S_UPD: begin
        sel           = chain_i[NUM_CENTROIDS];
        ctrl.upd_en   = 1'b1;
        ctrl.clr_dist = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_FSTART: begin
        if (cur_cnt == '0) begin
          state_d = S_FEMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (div_done) state_d = S_FEMIT;
      end
      S_FEMIT: begin
        if (out_free) begin
          if (cidx_q == LastCluster && didx_q == LastDim) begin
            ctrl.clr_all = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_FSTART;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      scan_q        <= '0;
      cidx_q        <= '0;
      didx_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ACC) scan_q <= '0;
      if (state_q == S_SCAN) scan_q <= scan_q + 1'b1;
      if (accept && in_cmd == CMD_FINALIZE) begin
        cidx_q <= '0;
        didx_q <= '0;
      end
      if ((state_q == S_EMIT || state_q == S_FEMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state_q == S_FEMIT && out_free) begin
        if (didx_q == LastDim) begin
          didx_q <= '0;
          cidx_q <= cidx_q + 1'b1;
        end else begin
          didx_q <= didx_q + 1'b1;
        end
      end
    end
  end

  logic [7:0] bi8, ci8, di8;
  assign bi8 = 8'(best_i_q);
  assign ci8 = 8'(cidx_q);
  assign di8 = 8'(didx_q);

  always_ff @(posedge clk_i) begin
    if (accept && in_cmd == CMD_POINT && dsel_ok) begin
      pbuf_q[dsel8[DW-1:0]] <= in_val;
      last_q                <= (dsel8[DW-1:0] == LastDim);
    end
    if (state_q == S_UPD) begin
      best_i_q <= chain_i[NUM_CENTROIDS];
      best_d_q <= chain_d[NUM_CENTROIDS];
    end
    if (state_q == S_FSTART) begin
      neg_q  <= cur_sum[63];
      mean_q <= '0;
    end
    // Truncated quotient, clamped to the 32-bit range with the sum's sign.
    if (state_q == S_FWAIT && div_done) begin
      if (neg_q) begin
        mean_q <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
      end else begin
        mean_q <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
    end
    if (state_q == S_EMIT && out_free) begin
      m_axis_tuser  <= KIND_ASSIGN;
      m_axis_tlast  <= 1'b1;
      m_axis_tdata  <= {3'd0, 1'b0, counts[best_i_q], best_d_q, 32'd0, 2'd0, bi8[1:0]};
    end
    if (state_q == S_FEMIT && out_free) begin
      m_axis_tuser  <= KIND_MEAN;
      m_axis_tlast  <= (cidx_q == LastCluster) && (didx_q == LastDim);
      m_axis_tdata  <= {3'd0, (cur_cnt == '0), cur_cnt, 64'd0, mean_q, di8[1:0], ci8[1:0]};
    end
  end

endmodule
